FILE: hdl/line_rasterizer_macros.svh
// Assertion macros shared by the line rasterizer RTL.
`ifndef LINE_RASTERIZER_MACROS_SVH
`define LINE_RASTERIZER_MACROS_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every clock edge out of reset
`define LR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// ante implies cons in the same cycle
`define LR_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// ante implies cons in the next cycle
`define LR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define LR_ASSERT(lbl, clk, rstn, prop, msg)
`define LR_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define LR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: hdl/lrast_pkg.sv
package lrast_pkg;

    localparam int COORD_BITS  = 12;
    localparam int ERR_BITS    = COORD_BITS + 2;
    localparam int QUEUE_DEPTH = 2;

    localparam int STRIDE_BITS = 16;
    localparam int BPP_BITS    = 3;
    localparam int ADDR_BITS   = 32;
    localparam int COLOR_BITS  = 32;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [ADDR_BITS-1:0]   BASE_RESET   = '0;
    localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 16'd7680;
    localparam logic [BPP_BITS-1:0]    BPP_RESET    = 3'd4;

    typedef enum logic [0:0] {
        REQ_START = 1'b0,
        REQ_STEP  = 1'b1
    } req_type_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BASE_ADDRESS    = 2'd0,
        CFG_ROW_STRIDE      = 2'd1,
        CFG_BYTES_PER_PIXEL = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic                  req_type;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
        logic [COLOR_BITS-1:0] color;
    } lrast_in_t;

    typedef struct packed {
        logic                  pixel_valid;
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [ADDR_BITS-1:0]  pixel_address;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  last_pixel;
    } lrast_out_t;

    // pixel as produced by the stepper, before address generation
    typedef struct packed {
        logic                  pixel_valid;
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  last_pixel;
    } lrast_pix_t;

endpackage

FILE: hdl/lrast_front.sv
`include "line_rasterizer_macros.svh"

module lrast_front
    import lrast_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  lrast_in_t  s_data,
    input  logic       q_ready,
    output logic       q_push,
    output lrast_pix_t q_entry
);

    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0] goal_x_reg, goal_x_next;
    logic [COORD_BITS-1:0] goal_y_reg, goal_y_next;
    logic [COORD_BITS-1:0] delta_x_reg, delta_x_next;
    logic [COORD_BITS-1:0] delta_y_reg, delta_y_next;
    logic                  dir_x_neg_reg, dir_x_neg_next;
    logic                  dir_y_neg_reg, dir_y_neg_next;
    logic [ERR_BITS-1:0]   err_reg, err_next;
    logic [COLOR_BITS-1:0] color_reg, color_next;
    logic                  active_reg, active_next;

    logic                  accept;
    logic                  is_step;
    logic signed [ERR_BITS:0] e2_s, dx_s, dy_s, err_sum;
    logic                  move_x, move_y;
    logic [COORD_BITS-1:0] step_x, step_y;
    logic [COORD_BITS-1:0] adx, ady;
    logic                  start_last, step_last;

    assign s_ready = q_ready;
    assign accept  = s_valid && q_ready;
    assign q_push  = accept;
    assign is_step = (s_data.req_type == REQ_STEP);

    assign e2_s = {err_reg, 1'b0};
    assign dx_s = $signed({{(ERR_BITS + 1 - COORD_BITS){1'b0}}, delta_x_reg});
    assign dy_s = $signed({{(ERR_BITS + 1 - COORD_BITS){1'b0}}, delta_y_reg});
    assign move_x = (e2_s > -dy_s);
    assign move_y = (e2_s < dx_s);

    assign step_x = move_x ? (dir_x_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1)
                           : cur_x_reg;
    assign step_y = move_y ? (dir_y_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1)
                           : cur_y_reg;

    always_comb begin
        err_sum = $signed({err_reg[ERR_BITS-1], err_reg});
        if (move_x) begin
            err_sum = err_sum - dy_s;
        end
        if (move_y) begin
            err_sum = err_sum + dx_s;
        end
    end

    assign adx = (s_data.start_x > s_data.end_x) ? s_data.start_x - s_data.end_x
                                                 : s_data.end_x - s_data.start_x;
    assign ady = (s_data.start_y > s_data.end_y) ? s_data.start_y - s_data.end_y
                                                 : s_data.end_y - s_data.start_y;

    assign start_last = (s_data.start_x == s_data.end_x) && (s_data.start_y == s_data.end_y);
    assign step_last  = (step_x == goal_x_reg) && (step_y == goal_y_reg);

    always_comb begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        goal_x_next    = goal_x_reg;
        goal_y_next    = goal_y_reg;
        delta_x_next   = delta_x_reg;
        delta_y_next   = delta_y_reg;
        dir_x_neg_next = dir_x_neg_reg;
        dir_y_neg_next = dir_y_neg_reg;
        err_next       = err_reg;
        color_next     = color_reg;
        active_next    = active_reg;
        q_entry        = '0;
        if (!is_step) begin
            cur_x_next     = s_data.start_x;
            cur_y_next     = s_data.start_y;
            goal_x_next    = s_data.end_x;
            goal_y_next    = s_data.end_y;
            delta_x_next   = adx;
            delta_y_next   = ady;
            dir_x_neg_next = !(s_data.start_x < s_data.end_x);
            dir_y_neg_next = !(s_data.start_y < s_data.end_y);
            err_next       = ERR_BITS'({2'b00, adx}) - ERR_BITS'({2'b00, ady});
            color_next     = s_data.color;
            active_next    = !start_last;
            q_entry.pixel_valid = 1'b1;
            q_entry.pixel_x     = s_data.start_x;
            q_entry.pixel_y     = s_data.start_y;
            q_entry.pixel_color = s_data.color;
            q_entry.last_pixel  = start_last;
        end else if (active_reg) begin
            cur_x_next  = step_x;
            cur_y_next  = step_y;
            err_next    = err_sum[ERR_BITS-1:0];
            active_next = !step_last;
            q_entry.pixel_valid = 1'b1;
            q_entry.pixel_x     = step_x;
            q_entry.pixel_y     = step_y;
            q_entry.pixel_color = color_reg;
            q_entry.last_pixel  = step_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            goal_x_reg    <= '0;
            goal_y_reg    <= '0;
            delta_x_reg   <= '0;
            delta_y_reg   <= '0;
            dir_x_neg_reg <= 1'b0;
            dir_y_neg_reg <= 1'b0;
            err_reg       <= '0;
            color_reg     <= '0;
            active_reg    <= 1'b0;
        end else if (accept) begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            goal_x_reg    <= goal_x_next;
            goal_y_reg    <= goal_y_next;
            delta_x_reg   <= delta_x_next;
            delta_y_reg   <= delta_y_next;
            dir_x_neg_reg <= dir_x_neg_next;
            dir_y_neg_reg <= dir_y_neg_next;
            err_reg       <= err_next;
            color_reg     <= color_next;
            active_reg    <= active_next;
        end
    end

    `LR_ASSERT_NEXT(a_last_idles, aclk, aresetn, accept && q_entry.last_pixel, !active_reg, "line still active after last pixel")
    `LR_ASSERT_SAME(a_idle_step, aclk, aresetn, accept && is_step && !active_reg, !q_entry.pixel_valid, "idle step produced a pixel")

endmodule

FILE: hdl/lrast_queue.sv
`include "line_rasterizer_macros.svh"

module lrast_queue
    import lrast_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  lrast_pix_t push_entry,
    output logic       push_ready,
    output logic       pop_valid,
    input  logic       pop,
    output lrast_pix_t pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lrast_pix_t        mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `LR_ASSERT(a_count_range, aclk, aresetn, count_reg <= CNT_W'(DEPTH), "queue count overflow")
    `LR_ASSERT_SAME(a_empty_ptrs, aclk, aresetn, count_reg == '0, rd_ptr_reg == wr_ptr_reg, "empty queue with unequal pointers")

endmodule

FILE: hdl/lrast_back.sv
`include "line_rasterizer_macros.svh"

module lrast_back
    import lrast_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    input  lrast_pix_t             q_entry,
    output logic                   q_pop,
    input  logic [ADDR_BITS-1:0]   base_address,
    input  logic [STRIDE_BITS-1:0] row_stride,
    input  logic [BPP_BITS-1:0]    bytes_per_pixel,
    output logic                   m_valid,
    input  logic                   m_ready,
    output lrast_out_t             m_data
);

    localparam int YOFF_BITS = COORD_BITS + STRIDE_BITS;
    localparam int XOFF_BITS = COORD_BITS + BPP_BITS;

    logic                  s1_valid_reg;
    lrast_pix_t            s1_pix_reg;
    logic [YOFF_BITS-1:0]  s1_yoff_reg;
    logic [XOFF_BITS-1:0]  s1_xoff_reg;
    logic                  m_valid_reg;
    lrast_out_t            m_data_reg, m_data_next;
    logic                  s1_adv, s2_adv;
    logic [ADDR_BITS-1:0]  addr_sum;

    assign s2_adv = !m_valid_reg || m_ready;
    assign s1_adv = !s1_valid_reg || s2_adv;
    assign q_pop  = q_valid && s1_adv;

    assign addr_sum = base_address + ADDR_BITS'(s1_yoff_reg) + ADDR_BITS'(s1_xoff_reg);

    always_comb begin
        m_data_next.pixel_valid   = s1_pix_reg.pixel_valid;
        m_data_next.pixel_x       = s1_pix_reg.pixel_x;
        m_data_next.pixel_y       = s1_pix_reg.pixel_y;
        m_data_next.pixel_address = s1_pix_reg.pixel_valid ? addr_sum : '0;
        m_data_next.pixel_color   = s1_pix_reg.pixel_color;
        m_data_next.last_pixel    = s1_pix_reg.last_pixel;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_adv) begin
                s1_valid_reg <= q_valid;
            end
            if (s2_adv) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_pix_reg  <= q_entry;
            s1_yoff_reg <= YOFF_BITS'(q_entry.pixel_y) * YOFF_BITS'(row_stride);
            s1_xoff_reg <= XOFF_BITS'(q_entry.pixel_x) * XOFF_BITS'(bytes_per_pixel);
        end
        if (s2_adv && s1_valid_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `LR_ASSERT_SAME(a_empty_result, aclk, aresetn, m_valid_reg && !m_data_reg.pixel_valid, (m_data_reg.pixel_address == '0) && !m_data_reg.last_pixel, "empty result carries address or last flag")

endmodule

FILE: hdl/line_rasterizer.sv
// Path: an input transfer is written into the queue, then into stage s1 (multiply),
// then into the output register (address add), which drives m_valid.
// Throughput: one item per cycle while the queue has room; one error update per item.
// The output register and a 2-deep queue let input transfers continue while m_ready is low.
// Reset (aresetn low, synchronous): line idle, queue and pipeline empty,
// base_address 0, row_stride 7680, bytes_per_pixel 4. No clearing pass.
module line_rasterizer
    import lrast_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  lrast_in_t               s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output lrast_out_t              m_data,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [ADDR_BITS-1:0]    cfg_data
);

    logic [ADDR_BITS-1:0]   base_reg;
    logic [STRIDE_BITS-1:0] stride_reg;
    logic [BPP_BITS-1:0]    bpp_reg;

    logic       q_push, q_ready, q_valid, q_pop;
    lrast_pix_t q_in, q_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg   <= BASE_RESET;
            stride_reg <= STRIDE_RESET;
            bpp_reg    <= BPP_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_BASE_ADDRESS:    base_reg   <= cfg_data;
                CFG_ROW_STRIDE:      stride_reg <= cfg_data[STRIDE_BITS-1:0];
                CFG_BYTES_PER_PIXEL: bpp_reg    <= cfg_data[BPP_BITS-1:0];
                default: ;
            endcase
        end
    end

    lrast_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_entry (q_in)
    );

    lrast_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .push_ready (q_ready),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_entry  (q_out)
    );

    lrast_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_entry         (q_out),
        .q_pop           (q_pop),
        .base_address    (base_reg),
        .row_stride      (stride_reg),
        .bytes_per_pixel (bpp_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data)
    );

endmodule

FILE: tb/line_rasterizer_tb.sv
`timescale 1ns / 100ps

module line_rasterizer_tb;
    import lrast_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED = 2'd3;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    lrast_in_t               s_data    = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b0;
    lrast_out_t              m_data;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [ADDR_BITS-1:0]    cfg_data  = '0;

    line_rasterizer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // framebuffer settings as the block should hold them
    logic [ADDR_BITS-1:0]   fb_base   = BASE_RESET;
    logic [STRIDE_BITS-1:0] fb_stride = STRIDE_RESET;
    logic [BPP_BITS-1:0]    fb_bpp    = BPP_RESET;

    // line walker state
    logic [COORD_BITS-1:0]  ln_x = '0, ln_y = '0, ln_goal_x = '0, ln_goal_y = '0;
    logic [COORD_BITS-1:0]  ln_dx = '0, ln_dy = '0;
    logic                   ln_x_neg = 1'b0, ln_y_neg = 1'b0;
    logic signed [ERR_BITS-1:0] ln_err = '0;
    logic [COLOR_BITS-1:0]  ln_color = '0;
    logic                   ln_active = 1'b0;

    lrast_out_t pending_pixels[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent    = 0;
    int lines_started = 0;
    int pixels_seen   = 0;
    int results_seen  = 0;
    int cfg_writes    = 0;
    int mismatches    = 0;
    int cycles        = 0;

    task automatic predict_pixel(input lrast_in_t item);
        lrast_out_t px;
        int         err;
        int         e2;
        logic       emit_pixel;
        px = '0;
        emit_pixel = 1'b1;
        if (item.req_type == REQ_START) begin
            ln_x      = item.start_x;
            ln_y      = item.start_y;
            ln_goal_x = item.end_x;
            ln_goal_y = item.end_y;
            ln_dx = (item.start_x > item.end_x) ? item.start_x - item.end_x
                                                : item.end_x - item.start_x;
            ln_dy = (item.start_y > item.end_y) ? item.start_y - item.end_y
                                                : item.end_y - item.start_y;
            ln_x_neg = !(item.start_x < item.end_x);
            ln_y_neg = !(item.start_y < item.end_y);
            err = int'(ln_dx) - int'(ln_dy);
            ln_err = err[ERR_BITS-1:0];
            ln_color = item.color;
            lines_started++;
        end else if (!ln_active) begin
            emit_pixel = 1'b0;
        end else begin
            err = ln_err;
            e2 = 2 * err;
            if (e2 > -int'(ln_dy)) begin
                err = err - int'(ln_dy);
                ln_x = ln_x_neg ? ln_x - 1'b1 : ln_x + 1'b1;
            end
            if (e2 < int'(ln_dx)) begin
                err = err + int'(ln_dx);
                ln_y = ln_y_neg ? ln_y - 1'b1 : ln_y + 1'b1;
            end
            ln_err = err[ERR_BITS-1:0];
        end
        if (emit_pixel) begin
            px.pixel_valid   = 1'b1;
            px.pixel_x       = ln_x;
            px.pixel_y       = ln_y;
            px.pixel_address = fb_base + ADDR_BITS'(ln_y) * ADDR_BITS'(fb_stride)
                             + ADDR_BITS'(ln_x) * ADDR_BITS'(fb_bpp);
            px.pixel_color   = ln_color;
            px.last_pixel    = (ln_x == ln_goal_x) && (ln_y == ln_goal_y);
            ln_active        = !px.last_pixel;
        end
        pending_pixels.push_back(px);
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        lrast_out_t want;
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     pending_pixels.size());
            $display("line_rasterizer_tb failed");
            $finish;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_pixels.size() == 0) begin
                    $error("result transfer with nothing pending: %p", m_data);
                    mismatches++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (want.pixel_valid) pixels_seen++;
                    check_field("pixel_valid", want.pixel_valid, m_data.pixel_valid);
                    check_field("pixel_x", want.pixel_x, m_data.pixel_x);
                    check_field("pixel_y", want.pixel_y, m_data.pixel_y);
                    check_field("pixel_address", want.pixel_address, m_data.pixel_address);
                    check_field("pixel_color", want.pixel_color, m_data.pixel_color);
                    check_field("last_pixel", want.last_pixel, m_data.last_pixel);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(input lrast_in_t item);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        predict_pixel(item);
        items_sent++;
    endtask

    // drop valid and wait until every pending result has been checked
    task automatic wait_results(input int extra);
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [ADDR_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_BASE_ADDRESS:    fb_base   = value;
            CFG_ROW_STRIDE:      fb_stride = value[STRIDE_BITS-1:0];
            CFG_BYTES_PER_PIXEL: fb_bpp    = value[BPP_BITS-1:0];
            default: ;
        endcase
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic lrast_in_t random_item(input req_type_t kind);
        lrast_in_t it;
        it.req_type = kind;
        it.start_x  = COORD_BITS'($urandom);
        it.start_y  = COORD_BITS'($urandom);
        it.end_x    = COORD_BITS'($urandom);
        it.end_y    = COORD_BITS'($urandom);
        it.color    = $urandom;
        return it;
    endfunction

    function automatic logic [COORD_BITS-1:0] coord_near(input logic [COORD_BITS-1:0] c,
                                                         input int span);
        int v;
        v = int'(c) + int'($urandom_range(2 * span)) - span;
        if (v < 0) v = 0;
        if (v > (1 << COORD_BITS) - 1) v = (1 << COORD_BITS) - 1;
        return v[COORD_BITS-1:0];
    endfunction

    task automatic start_line(input int sx, input int sy, input int ex, input int ey,
                              input logic [COLOR_BITS-1:0] color);
        lrast_in_t it;
        it = random_item(REQ_START);
        it.start_x = sx[COORD_BITS-1:0];
        it.start_y = sy[COORD_BITS-1:0];
        it.end_x   = ex[COORD_BITS-1:0];
        it.end_y   = ey[COORD_BITS-1:0];
        it.color   = color;
        send_item(it);
    endtask

    task automatic finish_line(input int cap);
        int n;
        n = 0;
        while (ln_active && n < cap) begin
            send_item(random_item(REQ_STEP));
            n++;
        end
    endtask

    task automatic test_idle_and_single_pixel();
        send_item(random_item(REQ_STEP));
        start_line(0, 0, 0, 0, '0);
        send_item(random_item(REQ_STEP));
        start_line(4095, 4095, 4095, 4095, '1);
        send_item(random_item(REQ_STEP));
    endtask

    task automatic test_short_lines();
        start_line(0, 0, 3, 1, 32'h1234_5678);
        finish_line(10);
        start_line(4095, 4095, 4094, 4092, 32'hA5A5_5A5A);
        finish_line(10);
        // vertical, abandoned after one step by a horizontal line
        start_line(10, 20, 10, 17, 32'h0000_00FF);
        finish_line(1);
        start_line(100, 5, 103, 5, 32'hFF00_0000);
        finish_line(10);
        wait_results(DRAIN_CYCLES);
    endtask

    task automatic test_config_extremes();
        cfg_write(CFG_BASE_ADDRESS, '1);
        cfg_write(CFG_ROW_STRIDE, 32'h0000_FFFF);
        cfg_write(CFG_BYTES_PER_PIXEL, 32'd7);
        start_line(4095, 4095, 4093, 4095, '1);
        finish_line(10);
        wait_results(DRAIN_CYCLES);
        cfg_write(CFG_BASE_ADDRESS, '0);
        cfg_write(CFG_ROW_STRIDE, 32'hFFFF_0000);
        cfg_write(CFG_BYTES_PER_PIXEL, 32'hFFFF_FFF8);
        start_line(4095, 0, 4095, 0, 32'h8000_0001);
        wait_results(DRAIN_CYCLES);
        cfg_write(CFG_BYTES_PER_PIXEL, 32'd1);
        cfg_write(CFG_ROW_STRIDE, $urandom);
        cfg_write(CFG_UNMAPPED, $urandom);
        start_line(7, 4000, 9, 4003, $urandom);
        finish_line(10);
        wait_results(DRAIN_CYCLES);
    endtask

    task automatic draw_random_line();
        lrast_in_t it;
        int        span;
        int        cap;
        it = random_item(REQ_START);
        if ($urandom_range(15) == 0) begin
            it.end_x = it.start_x;
            it.end_y = it.start_y;
        end else if ($urandom_range(7) != 0) begin
            span = $urandom_range(1, 40);
            it.end_x = coord_near(it.start_x, span);
            it.end_y = coord_near(it.start_y, span);
        end
        send_item(it);
        // long lines are cut short and abandoned by the next start
        cap = ($urandom_range(9) == 0) ? $urandom_range(20) : 60;
        finish_line(cap);
        if ($urandom_range(7) == 0) send_item(random_item(REQ_STEP));
    endtask

    task automatic test_random_lines(input int n_items, input int snd_idle,
                                     input int rcv_idle);
        int first;
        send_idle_pct = snd_idle;
        recv_idle_pct = rcv_idle;
        first = items_sent;
        while (items_sent - first < n_items) begin
            case ($urandom_range(29))
                0:       send_item(random_item(REQ_STEP));
                1:       wait_results(0);
                default: draw_random_line();
            endcase
        end
        wait_results(DRAIN_CYCLES);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 6;
        recv_idle_pct = 45;
        test_idle_and_single_pixel();
        test_short_lines();
        test_config_extremes();

        cfg_write(CFG_BASE_ADDRESS, $urandom);
        cfg_write(CFG_ROW_STRIDE, 32'd7680);
        cfg_write(CFG_BYTES_PER_PIXEL, 32'd4);
        test_random_lines(580, 6, 45);

        cfg_write(CFG_BASE_ADDRESS, $urandom);
        cfg_write(CFG_ROW_STRIDE, $urandom);
        cfg_write(CFG_BYTES_PER_PIXEL, $urandom);
        test_random_lines(580, 45, 6);

        cfg_write(CFG_BASE_ADDRESS, 32'hFFFF_F000);
        cfg_write(CFG_ROW_STRIDE, 32'h0000_FFFF);
        cfg_write(CFG_BYTES_PER_PIXEL, 32'd3);
        test_random_lines(580, 0, 0);

        wait_results(DRAIN_CYCLES);
        $display("covered %0d items over %0d lines, %0d results (%0d pixels) checked",
                 items_sent, lines_started, results_seen, pixels_seen);
        $display("%0d register writes, %0d mismatches", cfg_writes, mismatches);
        if (mismatches == 0) begin
            $display("line_rasterizer_tb passed");
        end else begin
            $display("line_rasterizer_tb failed");
        end
        $finish;
    end

endmodule

FILE: line_rasterizer.f
+incdir+hdl
hdl/lrast_pkg.sv
hdl/lrast_front.sv
hdl/lrast_queue.sv
hdl/lrast_back.sv
hdl/line_rasterizer.sv
tb/line_rasterizer_tb.sv
